[rtl/nfc_pkg.sv]
// Package for the numeric format converter: payload structs, mode codes,
// width selector and the shared leading-zero counter. No dependencies.
package nfc_pkg;

    typedef struct packed {
        logic [31:0] value_in;
        logic        last_element;
    } t_nfc_in;

    typedef struct packed {
        logic [63:0] value_out;
        logic        end_of_block;
    } t_nfc_out;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2
    } t_nfc_width;

    typedef enum logic [1:0] {
        CFG_CONV_MODE  = 2'd0,
        CFG_SCALE_BITS = 2'd1,
        CFG_SATURATE   = 2'd2
    } t_nfc_cfg_idx;

    localparam logic [4:0] MODE_ZX_8_16   = 5'd0;
    localparam logic [4:0] MODE_ZX_8_32   = 5'd1;
    localparam logic [4:0] MODE_ZX_16_32  = 5'd2;
    localparam logic [4:0] MODE_ZX_16_64  = 5'd3;
    localparam logic [4:0] MODE_ZX_32_64  = 5'd4;
    localparam logic [4:0] MODE_SX_8_16   = 5'd5;
    localparam logic [4:0] MODE_SX_8_32   = 5'd6;
    localparam logic [4:0] MODE_SX_16_32  = 5'd7;
    localparam logic [4:0] MODE_SX_16_64  = 5'd8;
    localparam logic [4:0] MODE_SX_32_64  = 5'd9;
    localparam logic [4:0] MODE_TR_16_8   = 5'd10;
    localparam logic [4:0] MODE_TR_32_8   = 5'd11;
    localparam logic [4:0] MODE_TR_32_16  = 5'd12;
    localparam logic [4:0] MODE_I32_F32   = 5'd13;
    localparam logic [4:0] MODE_I16_F32   = 5'd14;
    localparam logic [4:0] MODE_I8_F32    = 5'd15;
    localparam logic [4:0] MODE_F32_I32   = 5'd16;
    localparam logic [4:0] MODE_F32_I16   = 5'd17;
    localparam logic [4:0] MODE_F32_I8    = 5'd18;

    localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    // Count leading zeros of a nonzero word.
    function automatic logic [4:0] lzc32(input logic [31:0] x);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

[rtl/nfc_i2f.sv]
// Signed integer to float32 conversion, round to nearest even.
// Depends on nfc_pkg.
module nfc_i2f (
    input  logic [31:0]         i_value,
    input  nfc_pkg::t_nfc_width i_width,
    output logic [31:0]         o_float
);
    import nfc_pkg::*;

    logic [31:0] sx;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic [31:0] norm;
    logic        rnd;
    logic [24:0] mant;
    logic [32:0] total;

    always_comb begin
        unique case (i_width)
            W8:      sx = {{24{i_value[7]}}, i_value[7:0]};
            W16:     sx = {{16{i_value[15]}}, i_value[15:0]};
            default: sx = i_value;
        endcase
        mag   = sx[31] ? (~sx + 32'd1) : sx;
        lz    = lzc32(mag);
        norm  = mag << lz;
        rnd   = norm[7] & ((|norm[6:0]) | norm[8]);
        mant  = {1'b0, norm[31:8]} + {24'd0, rnd};
        // implicit bit of the mantissa carries into the exponent
        total = {2'b00, 8'(8'd157 - {3'b000, lz}), 23'd0} + {8'd0, mant};
        if (mag == 32'd0) begin
            o_float = 32'd0;
        end else begin
            o_float = {sx[31], total[30:0]};
        end
    end

endmodule

[rtl/nfc_fmul.sv]
// Three-stage float32 multiplier with single rounding to nearest even:
// unpack, 24x24 product, normalize and round. Depends on nfc_pkg.
module nfc_fmul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_scale_on,
    output logic [31:0] o_p
);
    import nfc_pkg::*;

    typedef struct packed {
        logic              sign;
        logic [23:0]       ma;
        logic [23:0]       mb;
        logic signed [9:0] ea;
        logic signed [9:0] eb;
        logic              spec;
        logic [31:0]       spec_val;
    } t_nfc_unp;

    t_nfc_unp n_u, r_u;

    logic [47:0]        r_prod;
    logic signed [10:0] r_exp;
    logic               r_sign;
    logic               r_spec;
    logic [31:0]        r_spec_val;
    logic [31:0]        r_p;

    function automatic logic [33:0] unpack(input logic [31:0] f);
        logic [4:0]  lz;
        logic [23:0] m;
        logic [9:0]  e;
        lz = lzc32({1'b0, f[22:0], 8'd0});
        if (f[30:23] != 8'd0) begin
            m = {1'b1, f[22:0]};
            e = 10'({2'b00, f[30:23]} - 10'd150);
        end else begin
            m = 24'({1'b0, f[22:0]} << lz);
            e = 10'(-10'sd149 - $signed({5'd0, lz}));
        end
        return {m, e};
    endfunction

    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [33:0] ua, ub;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        sgn    = i_a[31] ^ i_b[31];
        ua     = unpack(i_a);
        ub     = unpack(i_b);
        n_u.sign = sgn;
        n_u.ma   = ua[33:10];
        n_u.ea   = $signed(ua[9:0]);
        n_u.mb   = ub[33:10];
        n_u.eb   = $signed(ub[9:0]);
        n_u.spec = 1'b1;
        priority if (!i_scale_on) begin
            n_u.spec_val = i_a;
        end else if (a_nan) begin
            n_u.spec_val = i_a | QUIET_BIT;
        end else if (b_nan) begin
            n_u.spec_val = i_b | QUIET_BIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            n_u.spec_val = QNAN_DEFAULT;
        end else if (a_inf || b_inf) begin
            n_u.spec_val = {sgn, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            n_u.spec_val = {sgn, 31'd0};
        end else begin
            n_u.spec     = 1'b0;
            n_u.spec_val = 32'd0;
        end
    end

    logic [31:0]        n_p;
    logic               s;
    logic [47:0]        pn;
    logic signed [10:0] biased;
    logic [10:0]        sh_w;
    logic [4:0]         sh;
    logic [9:0]         eb;
    logic [73:0]        q;
    logic               rnd;
    logic [24:0]        mant;
    logic [32:0]        total;

    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_prod     <= r_u.ma * r_u.mb;
        r_exp      <= 11'(r_u.ea) + 11'(r_u.eb);
        r_sign     <= r_u.sign;
        r_spec     <= r_u.spec;
        r_spec_val <= r_u.spec_val;
        r_p        <= n_p;
    end

    always_comb begin
        s      = ~r_prod[47];
        pn     = s ? {r_prod[46:0], 1'b0} : r_prod;
        biased = r_exp + 11'sd174 - $signed({10'd0, s});
        sh_w   = 11'(11'sd1 - biased);
        if (biased > 11'sd0) begin
            sh = 5'd0;
            eb = 10'(biased - 11'sd1);
        end else begin
            sh = (biased < -11'sd25) ? 5'd26 : sh_w[4:0];
            eb = 10'd0;
        end
        q     = {pn, 26'd0} >> sh;
        rnd   = q[49] & ((|q[48:0]) | q[50]);
        mant  = {1'b0, q[73:50]} + {24'd0, rnd};
        total = {eb, 23'd0} + {8'd0, mant};
        if (r_spec) begin
            n_p = r_spec_val;
        end else if (total[32:23] >= 10'd255) begin
            n_p = {r_sign, 8'hFF, 23'd0};
        end else begin
            n_p = {r_sign, total[30:0]};
        end
    end

    assign o_p = r_p;

endmodule

[rtl/nfc_f2i.sv]
// Float32 to signed integer, truncation toward zero, optional clamping.
// Depends on nfc_pkg.
module nfc_f2i (
    input  logic [31:0]         i_float,
    input  nfc_pkg::t_nfc_width i_width,
    input  logic                i_sat,
    output logic [63:0]         o_value
);
    import nfc_pkg::*;

    logic        nan, big, over, sgn;
    logic [55:0] tmp;
    logic [32:0] mag;
    logic [33:0] lim_pos, lim_neg;
    logic [63:0] mask, minbits, maxbits, tval;
    logic [7:0]  e;

    always_comb begin
        unique case (i_width)
            W8: begin
                mask    = 64'h0000_0000_0000_00FF;
                lim_pos = 34'h7F;
            end
            W16: begin
                mask    = 64'h0000_0000_0000_FFFF;
                lim_pos = 34'h7FFF;
            end
            default: begin
                mask    = 64'h0000_0000_FFFF_FFFF;
                lim_pos = 34'h7FFF_FFFF;
            end
        endcase
        lim_neg = lim_pos + 34'd1;
        maxbits = {30'd0, lim_pos};
        minbits = {30'd0, lim_neg};
        sgn     = i_float[31];
        nan     = (i_float[30:23] == 8'hFF) && (i_float[22:0] != 23'd0);
        big     = i_float[30:23] >= 8'd160;
        e       = 8'(i_float[30:23] - 8'd127);
        tmp     = {32'd0, 1'b1, i_float[22:0]} << e[5:0];
        if (i_float[30:23] < 8'd127) begin
            mag = 33'd0;
        end else begin
            mag = tmp[55:23];
        end
        over = big || (sgn ? ({1'b0, mag} > lim_neg) : ({1'b0, mag} > lim_pos));
        tval = sgn ? (64'd0 - {31'd0, mag}) : {31'd0, mag};
        priority if (nan) begin
            o_value = i_sat ? 64'd0 : minbits;
        end else if (over) begin
            o_value = (i_sat && !sgn) ? maxbits : minbits;
        end else begin
            o_value = tval & mask;
        end
    end

endmodule

[rtl/numeric_format_converter.sv]
// Top level of the numeric format converter: configuration registers, integer
// modes and the pipeline around nfc_i2f, nfc_fmul and nfc_f2i. Uses nfc_pkg.
//
// Usage:
//   Input beat: drive i_in with start high; it is taken at any edge where
//   start is high and busy is low. busy is always low, so one beat may be
//   issued in every cycle.
//   Result beat: o_out is valid for exactly one cycle while o_strobe is high.
//   Results leave in the order beats came in, one per input beat.
//   Stages: a taken beat passes five register stages on its way to o_out:
//   convert in, unpack, multiply, round, convert out.
//   Throughput: one beat per cycle, fully pipelined.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 conv_mode, 1 scale_bits, 2 saturate_enable); other indexes are
//   dropped. Write only while no beat is in flight.
//   Reset: synchronous, active low; zeroes the config, valid and strobe flops,
//   emptying the pipeline. The receiver cannot stall, so nothing is held back.
module numeric_format_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  nfc_pkg::t_nfc_in  i_in,
    output logic              o_strobe,
    output nfc_pkg::t_nfc_out o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import nfc_pkg::*;

    logic [4:0]  r_conv_mode;
    logic [31:0] r_scale_bits;
    logic        r_saturate_enable;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_mode       <= 5'd0;
            r_scale_bits      <= 32'd0;
            r_saturate_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CONV_MODE:  r_conv_mode       <= i_cfg_data[4:0];
                CFG_SCALE_BITS: r_scale_bits      <= i_cfg_data;
                CFG_SATURATE:   r_saturate_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode mode into class and width
    logic       is_i2f, is_f2i;
    t_nfc_width width;
    always_comb begin
        is_i2f = (r_conv_mode == MODE_I32_F32) || (r_conv_mode == MODE_I16_F32) ||
                 (r_conv_mode == MODE_I8_F32);
        is_f2i = (r_conv_mode == MODE_F32_I32) || (r_conv_mode == MODE_F32_I16) ||
                 (r_conv_mode == MODE_F32_I8);
        if ((r_conv_mode == MODE_I8_F32) || (r_conv_mode == MODE_F32_I8)) begin
            width = W8;
        end else if ((r_conv_mode == MODE_I16_F32) || (r_conv_mode == MODE_F32_I16)) begin
            width = W16;
        end else begin
            width = W32;
        end
    end

    // stage 1: integer modes and the float operand
    logic [31:0] v;
    logic [63:0] n_int;
    logic [31:0] i2f_out;
    logic [31:0] n_fa;
    assign v = i_in.value_in;

    nfc_i2f u_i2f (
        .i_value (v),
        .i_width (width),
        .o_float (i2f_out)
    );

    always_comb begin
        unique case (r_conv_mode)
            MODE_ZX_8_16, MODE_ZX_8_32,
            MODE_TR_16_8, MODE_TR_32_8:   n_int = {56'd0, v[7:0]};
            MODE_ZX_16_32, MODE_ZX_16_64,
            MODE_TR_32_16:                n_int = {48'd0, v[15:0]};
            MODE_ZX_32_64:                n_int = {32'd0, v};
            MODE_SX_8_16:                 n_int = {48'd0, {8{v[7]}}, v[7:0]};
            MODE_SX_8_32:                 n_int = {32'd0, {24{v[7]}}, v[7:0]};
            MODE_SX_16_32:                n_int = {32'd0, {16{v[15]}}, v[15:0]};
            MODE_SX_16_64:                n_int = {{48{v[15]}}, v[15:0]};
            MODE_SX_32_64:                n_int = {{32{v[31]}}, v};
            default:                      n_int = 64'd0;
        endcase
        n_fa = is_i2f ? i2f_out : v;
    end

    logic [3:0]  r_valid;
    logic [3:0]  r_last;
    logic [63:0] r_int [4];
    logic [31:0] r_fa;

    // advance valid bits and the integer side path alongside the multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 4'd0;
        end else begin
            r_valid <= {r_valid[2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= {r_last[2:0], i_in.last_element};
        r_fa     <= n_fa;
        r_int[0] <= n_int;
        r_int[1] <= r_int[0];
        r_int[2] <= r_int[1];
        r_int[3] <= r_int[2];
    end

    // stages 2 to 4: optional scale multiply
    logic [31:0] fb;
    nfc_fmul u_fmul (
        .i_clk      (i_clk),
        .i_a        (r_fa),
        .i_b        (r_scale_bits),
        .i_scale_on (|r_scale_bits[30:0]),
        .o_p        (fb)
    );

    // stage 5: float to int and final select into the output register
    logic [63:0] f2i_out;
    logic [63:0] n_value;
    nfc_f2i u_f2i (
        .i_float (fb),
        .i_width (width),
        .i_sat   (r_saturate_enable),
        .o_value (f2i_out)
    );

    always_comb begin
        priority if (is_f2i) begin
            n_value = f2i_out;
        end else if (is_i2f) begin
            n_value = {32'd0, fb};
        end else begin
            n_value = r_int[3];
        end
    end

    logic     r_strobe;
    t_nfc_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_valid[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.value_out    <= n_value;
        r_out.end_of_block <= r_last[3];
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

[tb/tb_numeric_format_converter.sv]
// Self-checking testbench for numeric_format_converter: directed table plus
// randomized bursts, checked by a bit-accurate conversion predictor.
// Depends on rtl/nfc_pkg.sv and rtl/numeric_format_converter.sv.
`timescale 1ns / 100ps

module tb_numeric_format_converter;
    import nfc_pkg::*;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_nfc_in     i_in       = '0;
    logic        o_strobe;
    t_nfc_out    o_out;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [31:0] i_cfg_data = '0;

    // Pipeline depth from the block's own notes, plus margin.
    localparam int PIPE_DRAIN = 8;

    numeric_format_converter dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in      (i_in),
        .o_strobe  (o_strobe),
        .o_out     (o_out),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [4:0]  cur_mode;
    logic [31:0] cur_scale;
    logic        cur_sat;

    t_nfc_out pending_results[$];
    int       err_count;
    int       beats_sent;
    int       results_seen;

    // ------------------------------------------------------------------
    // Float32 arithmetic, done on integers so no simulator float is used.
    // ------------------------------------------------------------------

    // Round m * 2^e to float32, nearest-even, with subnormals and overflow.
    function automatic logic [31:0] round_to_f32(input logic sgn, input logic [127:0] m,
                                                 input int e);
        int           msb;
        int           sh;
        int           ee;
        logic [127:0] q;
        logic         guard;
        logic         sticky;
        msb = 0;
        for (int i = 0; i < 128; i++) begin
            if (m[i]) msb = i;
        end
        sh = msb - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh <= 0) begin
            q = m << (-sh);
            guard = 1'b0;
            sticky = 1'b0;
        end else begin
            q = (sh >= 128) ? 128'd0 : (m >> sh);
            guard = (sh - 1 < 128) ? m[sh-1] : 1'b0;
            sticky = |(m & ((128'd1 << (sh - 1)) - 128'd1));
        end
        if (guard && (sticky || q[0])) q = q + 128'd1;
        ee = e + sh;
        if (q[24]) begin
            q = q >> 1;
            ee++;
        end
        if (q == 0) return {sgn, 31'd0};
        if (q[23]) begin
            if (ee + 150 >= 255) return {sgn, 8'hFF, 23'd0};
            return {sgn, 8'(ee + 150), q[22:0]};
        end
        return {sgn, 8'd0, q[22:0]};
    endfunction

    function automatic logic f32_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic logic [31:0] f32_product(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        logic a_inf;
        logic b_inf;
        logic a_zero;
        logic b_zero;
        logic [23:0] ma;
        logic [23:0] mb;
        int ea;
        int eb;
        if (f32_is_nan(a)) return a | QUIET_BIT;
        if (f32_is_nan(b)) return b | QUIET_BIT;
        sgn = a[31] ^ b[31];
        a_inf = (a[30:23] == 8'hFF);
        b_inf = (b[30:23] == 8'hFF);
        a_zero = (a[30:0] == 0);
        b_zero = (b[30:0] == 0);
        if ((a_inf && b_zero) || (b_inf && a_zero)) return QNAN_DEFAULT;
        if (a_inf || b_inf) return {sgn, 8'hFF, 23'd0};
        if (a_zero || b_zero) return {sgn, 31'd0};
        ma = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
        mb = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
        ea = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
        eb = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
        return round_to_f32(sgn, 128'(ma) * 128'(mb), ea + eb);
    endfunction

    function automatic logic [31:0] int_to_f32(input logic [63:0] sx, input logic [31:0] scale);
        logic [31:0] fb;
        logic [63:0] mg;
        mg = sx[63] ? (64'd0 - sx) : sx;
        if (sx == 0) fb = 32'd0;
        else fb = round_to_f32(sx[63], 128'(mg), 0);
        if (scale[30:0] != 0) fb = f32_product(fb, scale);
        return fb;
    endfunction

    function automatic logic [63:0] f32_to_int(input logic [31:0] v, input int w,
                                               input logic [31:0] scale, input logic sat);
        logic [31:0]  fb;
        logic [63:0]  wmask;
        logic [63:0]  min_bits;
        logic [63:0]  max_val;
        logic [127:0] mag;
        logic         neg;
        int           e;
        fb = (scale[30:0] != 0) ? f32_product(v, scale) : v;
        wmask = (64'd1 << w) - 64'd1;
        min_bits = 64'd1 << (w - 1);
        max_val = min_bits - 64'd1;
        if (f32_is_nan(fb)) return sat ? 64'd0 : min_bits;
        neg = fb[31];
        if (fb[30:23] == 8'hFF) begin
            mag = '1;
        end else if (fb[30:23] == 0) begin
            mag = '0;
        end else begin
            e = int'(fb[30:23]) - 150;
            mag = (e >= 0) ? (128'({1'b1, fb[22:0]}) << e)
                           : (128'({1'b1, fb[22:0]}) >> (-e));
        end
        if (sat) begin
            if (!neg && mag >= 128'(max_val)) return max_val;
            if (neg && mag >= 128'(min_bits)) return min_bits;
        end else begin
            if (!neg && mag > 128'(max_val)) return min_bits;
            if (neg && mag > 128'(min_bits)) return min_bits;
        end
        return neg ? ((-mag[63:0]) & wmask) : (mag[63:0] & wmask);
    endfunction

    // Expected converted element for the current register settings.
    function automatic logic [63:0] convert_element(input logic [4:0] mode,
                                                    input logic [31:0] scale,
                                                    input logic sat, input logic [31:0] v);
        case (mode)
            MODE_ZX_8_16, MODE_ZX_8_32, MODE_TR_16_8, MODE_TR_32_8: return {56'd0, v[7:0]};
            MODE_ZX_16_32, MODE_ZX_16_64, MODE_TR_32_16:           return {48'd0, v[15:0]};
            MODE_ZX_32_64: return {32'd0, v};
            MODE_SX_8_16:  return {48'd0, {8{v[7]}}, v[7:0]};
            MODE_SX_8_32:  return {32'd0, {24{v[7]}}, v[7:0]};
            MODE_SX_16_32: return {32'd0, {16{v[15]}}, v[15:0]};
            MODE_SX_16_64: return {{48{v[15]}}, v[15:0]};
            MODE_SX_32_64: return {{32{v[31]}}, v};
            MODE_I32_F32:  return {32'd0, int_to_f32({{32{v[31]}}, v}, scale)};
            MODE_I16_F32:  return {32'd0, int_to_f32({{48{v[15]}}, v[15:0]}, scale)};
            MODE_I8_F32:   return {32'd0, int_to_f32({{56{v[7]}}, v[7:0]}, scale)};
            MODE_F32_I32:  return f32_to_int(v, 32, scale, sat);
            MODE_F32_I16:  return f32_to_int(v, 16, scale, sat);
            MODE_F32_I8:   return f32_to_int(v, 8, scale, sat);
            default:       return 64'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Drain the pipeline, then write all three registers.
    task automatic program_regs(input logic [4:0] mode, input logic [31:0] scale,
                                input logic sat);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_CONV_MODE;
        i_cfg_data <= {27'd0, mode};
        @(posedge i_clk);
        i_cfg_idx <= CFG_SCALE_BITS;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SATURATE;
        i_cfg_data <= {31'd0, sat};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
        cur_scale = scale;
        cur_sat = sat;
    endtask

    // Present one beat and hold it until taken; queue what it must produce.
    task automatic send_beat(input logic [31:0] v, input logic last_el,
                             input logic use_typed, input logic [63:0] typed_val);
        t_nfc_out want;
        start <= 1'b1;
        i_in <= '{value_in: v, last_element: last_el};
        do @(posedge i_clk); while (busy);
        want.value_out = use_typed ? typed_val
                                   : convert_element(cur_mode, cur_scale, cur_sat, v);
        want.end_of_block = last_el;
        pending_results.push_back(want);
        beats_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver never stalls, so every strobe is a beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_nfc_out want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h/%b",
                         $realtime, o_out.value_out, o_out.end_of_block);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.value_out !== want.value_out) begin
                    $display("%0t: value_out mismatch: expected %h, actual %h",
                             $realtime, want.value_out, o_out.value_out);
                    err_count++;
                end
                if (o_out.end_of_block !== want.end_of_block) begin
                    $display("%0t: end_of_block mismatch: expected %b, actual %b",
                             $realtime, want.end_of_block, o_out.end_of_block);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: register settings, input and, where obvious, result.
    // ------------------------------------------------------------------
    typedef struct {
        logic [4:0]  mode;
        logic [31:0] scale;
        logic        sat;
        logic [31:0] v;
        logic        last_el;
        logic        typed;
        logic [63:0] want;
    } t_dir_row;

    localparam int N_DIR = 25;

    t_dir_row dir_rows [N_DIR] = '{
        // reset state: zero-extend 8 to 16
        '{MODE_ZX_8_16,  32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'hFF},
        '{MODE_ZX_8_32,  32'h0, 1'b0, 32'h0000_00A5, 1'b0, 1'b0, 64'h0},
        '{MODE_ZX_16_32, 32'h0, 1'b0, 32'hDEAD_BEEF, 1'b0, 1'b0, 64'h0},
        '{MODE_ZX_16_64, 32'h0, 1'b0, 32'h0000_FFFF, 1'b1, 1'b0, 64'h0},
        '{MODE_ZX_32_64, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 64'hFFFF_FFFF},
        '{MODE_SX_8_16,  32'h0, 1'b0, 32'h0000_0080, 1'b0, 1'b1, 64'hFF80},
        '{MODE_SX_8_32,  32'h0, 1'b0, 32'h1234_567F, 1'b0, 1'b0, 64'h0},
        '{MODE_SX_16_32, 32'h0, 1'b0, 32'h0000_8001, 1'b1, 1'b0, 64'h0},
        '{MODE_SX_16_64, 32'h0, 1'b0, 32'h0000_8000, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_8000},
        '{MODE_SX_32_64, 32'h0, 1'b0, 32'h8000_0000, 1'b0, 1'b1, 64'hFFFF_FFFF_8000_0000},
        '{MODE_TR_16_8,  32'h0, 1'b0, 32'h1234_5678, 1'b0, 1'b1, 64'h78},
        '{MODE_TR_32_8,  32'h0, 1'b0, 32'h1234_5678, 1'b0, 1'b1, 64'h78},
        '{MODE_TR_32_16, 32'h0, 1'b0, 32'h1234_5678, 1'b1, 1'b1, 64'h5678},
        // int to float: most negative, rounding up to 2^31, minus one
        '{MODE_I32_F32,  32'h0, 1'b0, 32'h8000_0000, 1'b0, 1'b1, 64'hCF00_0000},
        '{MODE_I32_F32,  32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b1, 64'h4F00_0000},
        '{MODE_I16_F32,  32'h0, 1'b0, 32'h0000_FFFF, 1'b0, 1'b1, 64'hBF80_0000},
        // negative zero scale leaves the value unscaled
        '{MODE_I8_F32,   32'h8000_0000, 1'b0, 32'h0000_0003, 1'b0, 1'b1, 64'h4040_0000},
        // zero times infinite scale is invalid
        '{MODE_I32_F32,  32'h7F80_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b1, 64'h7FC0_0000},
        // NaN scale is quieted and passed on; element NaN wins over it
        '{MODE_I8_F32,   32'h7F80_0001, 1'b0, 32'h0000_0005, 1'b0, 1'b1, 64'h7FC0_0001},
        '{MODE_F32_I32,  32'h7F80_0001, 1'b0, 32'h7F80_0002, 1'b1, 1'b1, 64'h8000_0000},
        // float to int: NaN and infinity with clamping, overflow without it
        '{MODE_F32_I32,  32'h0, 1'b1, 32'h7FC0_0000, 1'b0, 1'b1, 64'h0},
        '{MODE_F32_I32,  32'h0, 1'b1, 32'h7F80_0000, 1'b0, 1'b1, 64'h7FFF_FFFF},
        '{MODE_F32_I8,   32'h0, 1'b0, 32'h4300_0000, 1'b0, 1'b1, 64'h80},
        '{MODE_F32_I16,  32'h4000_0000, 1'b0, 32'hBFC0_0000, 1'b0, 1'b0, 64'h0},
        // unused mode code yields zero
        '{5'd31,         32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0}
    };

    // Random float with exponent near the integer limits, else any pattern.
    function automatic logic [31:0] rand_float_near_int();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return {1'(($urandom())), 8'($urandom_range(110, 162)), 23'($urandom())};
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h3F80_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h7F80_0000;
            5:       return {1'(($urandom())), 8'd0, 23'($urandom())};
            6:       return {1'(($urandom())), 8'($urandom_range(100, 154)), 23'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          burst;
        int          phase_beats;
        logic [4:0]  m;
        logic [31:0] v;

        err_count = 0;
        beats_sent = 0;
        results_seen = 0;
        cur_mode = MODE_ZX_8_16;
        cur_scale = '0;
        cur_sat = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, back to back within one register setting.
        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].mode != cur_mode || dir_rows[r].scale != cur_scale
                    || dir_rows[r].sat != cur_sat) begin
                program_regs(dir_rows[r].mode, dir_rows[r].scale, dir_rows[r].sat);
            end
            send_beat(dir_rows[r].v, dir_rows[r].last_el, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random phases: new settings, then bursty traffic with random gaps.
        while (beats_sent < 1225) begin
            m = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
                                             : 5'($urandom_range(0, 18));
            program_regs(m, rand_scale(), 1'($urandom()));
            phase_beats = $urandom_range(20, 60);
            while (phase_beats > 0) begin
                burst = $urandom_range(1, 12);
                while (burst > 0 && phase_beats > 0) begin
                    v = (m >= MODE_F32_I32) ? rand_float_near_int() : $urandom();
                    send_beat(v, 1'($urandom()), 1'b0, 64'd0);
                    burst--;
                    phase_beats--;
                end
                // Hold start low for a gap, sometimes none.
                if ($urandom_range(0, 2) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
        start <= 1'b0;

        // Let the pipeline empty out.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);

        $display("Converted %0d elements over all mode codes, scale patterns and clamp",
                 beats_sent);
        $display("settings; %0d result beats checked, %0d mismatches.",
                 results_seen, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/nfc_pkg.sv
rtl/nfc_i2f.sv
rtl/nfc_fmul.sv
rtl/nfc_f2i.sv
rtl/numeric_format_converter.sv
tb/tb_numeric_format_converter.sv
